### sv/aes128_block_cipher_defines.svh
// assertion macros for the aes-128 block cipher
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// property holds on every edge out of reset
`define AES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// a condition on an edge implies a consequent in the next cycle
`define AES_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Types, constants and GF(2^8) round functions shared by the cipher cells.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int CFG_IDX_W  = 2;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [7:0]         t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH     = 2'd0,
        CFG_KEY_LOW      = 2'd1,
        CFG_ENCRYPT_MODE = 2'd2
    } t_cfg_idx;

    // data and control handed from one round cell to the next
    typedef struct packed {
        logic   vld;
        logic   enc;
        t_block state;
        t_block rkey;
    } t_cell_bus;

    function automatic t_byte sbox_fwd(input t_byte a);
        t_byte r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_byte sbox_inv(input t_byte a);
        t_byte r;
        case (a)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // forward round constant of round 1..10, zero elsewhere
    function automatic t_byte rcon(input logic [3:0] rnd);
        t_byte r;
        case (rnd)
            4'd1:  r = 8'h01;
            4'd2:  r = 8'h02;
            4'd3:  r = 8'h04;
            4'd4:  r = 8'h08;
            4'd5:  r = 8'h10;
            4'd6:  r = 8'h20;
            4'd7:  r = 8'h40;
            4'd8:  r = 8'h80;
            4'd9:  r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte n of a block, byte 0 in the top bits
    function automatic t_byte blk_byte(input t_block b, input int n);
        return b[BLOCK_W-1-8*n -: 8];
    endfunction

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]),
                sbox_fwd(w[7:0])};
    endfunction

    // round key of round rnd from round key of round rnd-1
    function automatic t_block key_fwd(input t_block k, input logic [3:0] rnd);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rcon(rnd), 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // round key of round rnd-1 from round key of round rnd
    function automatic t_block key_bwd(input t_block k, input logic [3:0] rnd);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        w3 = k[31:0] ^ k[63:32];
        w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        t  = sub_word({w3[23:0], w3[31:24]}) ^ {rcon(rnd), 24'h0};
        w0 = k[127:96] ^ t;
        return {w0, w1, w2, w3};
    endfunction

    function automatic t_block shift_rows(input t_block s, input logic fwd);
        t_block t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (fwd) begin
                    t[BLOCK_W-1-8*(r+4*c) -: 8] = blk_byte(s, r + 4*((c+r)%4));
                end else begin
                    t[BLOCK_W-1-8*(r+4*((c+r)%4)) -: 8] = blk_byte(s, r + 4*c);
                end
            end
        end
        return t;
    endfunction

    function automatic t_block sub_bytes(input t_block s, input logic fwd);
        t_block t;
        for (int i = 0; i < 16; i++) begin
            t[BLOCK_W-1-8*i -: 8] = fwd ? sbox_fwd(blk_byte(s, i)) : sbox_inv(blk_byte(s, i));
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic fwd);
        t_byte a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
        t_byte p0, p1, p2, p3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
        p0 = x0 ^ x1 ^ a1 ^ a2 ^ a3;
        p1 = a0 ^ x1 ^ x2 ^ a2 ^ a3;
        p2 = a0 ^ a1 ^ x2 ^ x3 ^ a3;
        p3 = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        // inverse mix = forward mix after multiplying by {04}(a0^a2),(a1^a3)
        y0 = xtime(xtime(a0 ^ a2));
        y1 = xtime(xtime(a1 ^ a3));
        z0 = a0 ^ y0; z1 = a1 ^ y1; z2 = a2 ^ y0; z3 = a3 ^ y1;
        x0 = xtime(z0); x1 = xtime(z1); x2 = xtime(z2); x3 = xtime(z3);
        y2 = x0 ^ x1 ^ z1 ^ z2 ^ z3;
        y3 = z0 ^ x1 ^ x2 ^ z2 ^ z3;
        y0 = z0 ^ z1 ^ x2 ^ x3 ^ z3;
        y1 = x0 ^ z0 ^ z1 ^ z2 ^ x3;
        return fwd ? {p0, p1, p2, p3} : {y2, y3, y0, y1};
    endfunction

    function automatic t_block mix_columns(input t_block s, input logic fwd);
        return {mix_col(s[127:96], fwd), mix_col(s[95:64], fwd),
                mix_col(s[63:32], fwd), mix_col(s[31:0], fwd)};
    endfunction

endpackage

### sv/aes_key_last.sv
// ----------------------------------------------------------------------------
// aes_key_last
// Registered last round key, expanded from the cipher key after each key change.
// ----------------------------------------------------------------------------
module aes_key_last (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aes_pkg::t_block      i_key,
    output aes_pkg::t_block      o_key_last,
    output logic                 o_ready
);
    // one round of expansion per cycle, restarted from the new key by any key change
    aes_pkg::t_block r_key_seen, n_key_seen;
    aes_pkg::t_block r_acc, n_acc;
    logic [3:0]      r_rnd, n_rnd;

    always_comb begin
        n_key_seen = i_key;
        n_acc      = r_acc;
        n_rnd      = r_rnd;
        if (i_key != r_key_seen) begin
            n_acc = i_key;
            n_rnd = 4'd1;
        end else if (r_rnd != 4'd0 && r_rnd <= 4'(aes_pkg::NUM_ROUNDS)) begin
            n_acc = aes_pkg::key_fwd(r_acc, r_rnd);
            n_rnd = r_rnd + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seen <= '0;
            r_acc      <= '0;
            r_rnd      <= 4'd1;
        end else begin
            r_key_seen <= n_key_seen;
            r_acc      <= n_acc;
            r_rnd      <= n_rnd;
        end
    end

    assign o_key_last = r_acc;
    assign o_ready    = (r_rnd == 4'(aes_pkg::NUM_ROUNDS + 1)) && (i_key == r_key_seen);
endmodule

### sv/aes_round_cell.sv
// ----------------------------------------------------------------------------
// aes_round_cell
// One cipher round: state transform and on-the-fly round key step.
// ----------------------------------------------------------------------------
module aes_round_cell #(
    parameter logic [3:0] RND = 4'd1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aes_pkg::t_cell_bus   i_bus,
    output aes_pkg::t_cell_bus   o_bus
);
    aes_pkg::t_cell_bus r_bus, n_bus;
    aes_pkg::t_block    w_key, w_enc, w_dec;

    // decryption walks key back from round 10; cell RND uses key 10-RND
    always_comb begin
        w_key = i_bus.enc ? aes_pkg::key_fwd(i_bus.rkey, RND)
                          : aes_pkg::key_bwd(i_bus.rkey, 4'(aes_pkg::NUM_ROUNDS + 1) - RND);
        w_enc = aes_pkg::shift_rows(aes_pkg::sub_bytes(i_bus.state, 1'b1), 1'b1);
        if (RND != 4'(aes_pkg::NUM_ROUNDS)) begin
            w_enc = aes_pkg::mix_columns(w_enc, 1'b1);
        end
        w_enc = w_enc ^ w_key;
        w_dec = aes_pkg::sub_bytes(aes_pkg::shift_rows(i_bus.state, 1'b0), 1'b0) ^ w_key;
        if (RND != 4'(aes_pkg::NUM_ROUNDS)) begin
            w_dec = aes_pkg::mix_columns(w_dec, 1'b0);
        end
        n_bus.vld   = i_bus.vld;
        n_bus.enc   = i_bus.enc;
        n_bus.state = i_bus.enc ? w_enc : w_dec;
        n_bus.rkey  = w_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else begin
            r_bus.vld <= n_bus.vld;
        end
        r_bus.enc   <= n_bus.enc;
        r_bus.state <= n_bus.state;
        r_bus.rkey  <= n_bus.rkey;
    end

    assign o_bus = r_bus;
endmodule

### sv/aes128_block_cipher.sv
// a block passes the input register and then the ten round cells before o_done
// throughput: one block per cycle unless busy; the ten-cell chain takes one each cycle
// after a key change the last round key for decryption is re-expanded, busy high meanwhile
// reset: synchronous active low, key zero, encrypt mode set, pipeline emptied
// results carry a one-cycle strobe and cannot be held off by the receiver
// ----------------------------------------------------------------------------
// aes128_block_cipher
// AES-128 encrypt/decrypt as a chain of ten registered round cells.
// ----------------------------------------------------------------------------
`include "aes128_block_cipher_defines.svh"

module aes128_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output logic        o_done,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    localparam int N = aes_pkg::NUM_ROUNDS;

    logic [63:0]        r_key_high, r_key_low;
    logic               r_enc;
    aes_pkg::t_block    w_key, w_key_last;
    logic               w_key_ready;
    logic               w_accept;
    aes_pkg::t_cell_bus r_in, n_in;
    aes_pkg::t_cell_bus w_chain [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_enc      <= 1'b1;
        end else if (i_cfg_we) begin
            case (aes_pkg::t_cfg_idx'(i_cfg_idx))
                aes_pkg::CFG_KEY_HIGH:     r_key_high <= i_cfg_data;
                aes_pkg::CFG_KEY_LOW:      r_key_low  <= i_cfg_data;
                aes_pkg::CFG_ENCRYPT_MODE: r_enc      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_key = {r_key_high, r_key_low};

    aes_key_last u_key_last (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (w_key),
        .o_key_last (w_key_last),
        .o_ready    (w_key_ready)
    );

    assign busy     = !w_key_ready;
    assign w_accept = start && !busy;

    // initial add round key on transfer
    always_comb begin
        n_in.vld   = w_accept;
        n_in.enc   = r_enc;
        n_in.rkey  = r_enc ? w_key : w_key_last;
        n_in.state = {i_block_high, i_block_low} ^ n_in.rkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in.vld <= n_in.vld;
        end
        r_in.enc   <= n_in.enc;
        r_in.state <= n_in.state;
        r_in.rkey  <= n_in.rkey;
    end

    assign w_chain[0] = r_in;

    for (genvar g = 1; g <= N; g++) begin : g_round
        aes_round_cell #(.RND(4'(g))) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_chain[g-1]),
            .o_bus   (w_chain[g])
        );
    end

    assign o_done        = w_chain[N].vld;
    assign o_result_high = w_chain[N].state[127:64];
    assign o_result_low  = w_chain[N].state[63:0];

    `AES_ASSERT_NEXT(a_accept_enters, w_accept, r_in.vld, "accepted block did not enter chain")
    `AES_ASSERT_NEXT(a_no_ghost, !w_accept, !r_in.vld, "chain entry without transfer")
    `AES_ASSERT(a_busy_no_accept, !(busy && r_in.vld && !$past(w_accept)), "entry while busy")
endmodule
